// ===== sv/ccp_pkg.sv =====
// Shared types and constants for the cylinder pushout pipeline.
package ccp_pkg;

  localparam int unsigned SQRT_CELLS = 32;
  localparam int unsigned DIV_CELLS  = 32;

  // Per-item sideband that rides along the whole pipeline.
  typedef struct packed {
    logic               push;
    logic               hit;
    logic               coin;
    logic signed [31:0] ax;
    logic signed [31:0] az;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bz;
    logic               sx;
    logic               sz;
    logic [32:0]        mx;
    logic [32:0]        mz;
    logic [31:0]        rng;
  } side_t;

  // Square root cell word: radicand shifts out two bits per cell.
  typedef struct packed {
    side_t       side;
    logic [63:0] s;
    logic [31:0] root;
    logic [33:0] rem;
  } sqrt_t;

  // Divider cell word: two lanes share one divisor.
  typedef struct packed {
    side_t       side;
    logic [32:0] d;
    logic [31:0] nx;
    logic [31:0] nz;
    logic [32:0] rx;
    logic [32:0] rz;
    logic [31:0] qx;
    logic [31:0] qz;
  } div_t;

endpackage

// ===== sv/ccp_if.sv =====
// Valid/ready channel interfaces for item input and result output.
interface ccp_in_if;
  import ccp_pkg::*;
  logic               valid;
  logic               ready;
  logic signed [31:0] a_x;
  logic signed [31:0] a_y;
  logic signed [31:0] a_z;
  logic [30:0]        a_radius;
  logic [30:0]        a_height;
  logic signed [31:0] b_x;
  logic signed [31:0] b_y;
  logic signed [31:0] b_z;
  logic [30:0]        b_radius;
  logic [30:0]        b_height;
  modport source (output valid, a_x, a_y, a_z, a_radius, a_height,
                  b_x, b_y, b_z, b_radius, b_height, input ready);
  modport sink   (input valid, a_x, a_y, a_z, a_radius, a_height,
                  b_x, b_y, b_z, b_radius, b_height, output ready);
endinterface

interface ccp_out_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic               coincident;
  logic signed [31:0] pushed_x;
  logic signed [31:0] pushed_y;
  logic signed [31:0] pushed_z;
  modport source (output valid, hit, coincident, pushed_x, pushed_y, pushed_z,
                  input ready);
  modport sink   (input valid, hit, coincident, pushed_x, pushed_y, pushed_z,
                   output ready);
endinterface

// ===== sv/ccp_sqrt_cell.sv =====
// One digit cell of the pipelined integer square root.
module ccp_sqrt_cell
  import ccp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  sqrt_t data_i,
  output logic  valid_o,
  output sqrt_t data_o
);

  logic        valid_q;
  sqrt_t       data_q, data_d;
  logic [35:0] t, trial, diff;
  logic        ge;

  always_comb begin
    t      = {data_i.rem, data_i.s[63:62]};
    trial  = {2'b00, data_i.root, 2'b01};
    diff   = t - trial;
    ge     = (t >= trial);
    data_d = data_i;
    data_d.s    = {data_i.s[61:0], 2'b00};
    data_d.root = {data_i.root[30:0], ge};
    data_d.rem  = ge ? diff[33:0] : t[33:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== sv/ccp_div_cell.sv =====
// One quotient-bit cell of the two-lane restoring divider.
module ccp_div_cell
  import ccp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  div_t data_i,
  output logic valid_o,
  output div_t data_o
);

  logic        valid_q;
  div_t        data_q, data_d;
  logic [33:0] tx, tz, dd, dfx, dfz;
  logic        gx, gz;

  always_comb begin
    dd  = {1'b0, data_i.d};
    tx  = {data_i.rx, data_i.nx[31]};
    tz  = {data_i.rz, data_i.nz[31]};
    dfx = tx - dd;
    dfz = tz - dd;
    gx  = (tx >= dd);
    gz  = (tz >= dd);
    data_d    = data_i;
    data_d.nx = {data_i.nx[30:0], 1'b0};
    data_d.nz = {data_i.nz[30:0], 1'b0};
    data_d.rx = gx ? dfx[32:0] : tx[32:0];
    data_d.rz = gz ? dfz[32:0] : tz[32:0];
    data_d.qx = {data_i.qx[30:0], gx};
    data_d.qz = {data_i.qz[30:0], gz};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== sv/cylinder_cylinder_pushout.sv =====
// Vertical cylinder pushout: fully pipelined, one pair per cycle while out_o is not stalled.
// A pair enters through in_i and its result leaves through out_o after
// one stage for the span test and axis deltas, one for the squares,
// one for the distance compare, 32 square root cells (two radicand bits
// each), one for the rounded root and the offset products, one for the
// rounding bias, 32 divider cells (one quotient bit each, x and z in
// parallel) and the output register that adds and saturates. The cells
// form one chain that advances on a common enable, so a new pair is taken
// in every cycle in which the output register is empty or being drained;
// the latency is set by the length of the cell chain. Coincident axes
// report hit and coincident with B's position unchanged.
module cylinder_cylinder_pushout
  import ccp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  ccp_in_if.sink    in_i,
  ccp_out_if.source out_o
);

  logic en;
  assign en = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  // ---- stage A: vertical span test, axis deltas, radius sum
  logic               a_v_q;
  side_t              a_side_q, a_side_d;
  logic               a_vmiss_q, a_vmiss_d;
  logic signed [33:0] ay_lo, by_lo, ay_hi, by_hi;
  logic signed [32:0] vx, vz;

  always_comb begin
    ay_lo = 34'(in_i.a_y);
    by_lo = 34'(in_i.b_y);
    ay_hi = ay_lo + $signed({3'b000, in_i.a_height});
    by_hi = by_lo + $signed({3'b000, in_i.b_height});
    a_vmiss_d = (ay_lo > by_hi) || (ay_hi < by_lo);
    vx = 33'(in_i.b_x) - 33'(in_i.a_x);
    vz = 33'(in_i.b_z) - 33'(in_i.a_z);
    a_side_d      = '0;
    a_side_d.ax   = in_i.a_x;
    a_side_d.az   = in_i.a_z;
    a_side_d.bx   = in_i.b_x;
    a_side_d.by   = in_i.b_y;
    a_side_d.bz   = in_i.b_z;
    a_side_d.sx   = vx[32];
    a_side_d.sz   = vz[32];
    a_side_d.mx   = vx[32] ? 33'(-vx) : 33'(vx);
    a_side_d.mz   = vz[32] ? 33'(-vz) : 33'(vz);
    a_side_d.rng  = {1'b0, in_i.a_radius} + {1'b0, in_i.b_radius};
  end

  // ---- stage B: squares
  logic        b_v_q;
  side_t       b_side_q;
  logic        b_vmiss_q;
  logic [65:0] b_sqx_q, b_sqz_q;
  logic [63:0] b_rr_q;

  // ---- stage C: distance compare, root chain head
  logic        c_v_q;
  sqrt_t       c_data_q, c_data_d;
  logic [66:0] s_sum;

  always_comb begin
    s_sum    = {1'b0, b_sqx_q} + {1'b0, b_sqz_q};
    c_data_d = '0;
    c_data_d.side      = b_side_q;
    c_data_d.side.hit  = !b_vmiss_q && (s_sum <= {3'b000, b_rr_q});
    c_data_d.side.coin = c_data_d.side.hit && (s_sum == '0);
    c_data_d.side.push = c_data_d.side.hit && (s_sum != '0);
    c_data_d.s         = s_sum[63:0];
  end

  // ---- square root chain
  logic  sq_v [SQRT_CELLS+1];
  sqrt_t sq_d [SQRT_CELLS+1];
  assign sq_v[0] = c_v_q;
  assign sq_d[0] = c_data_q;

  for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sqrt
    ccp_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_v[i]),
      .data_i  (sq_d[i]),
      .valid_o (sq_v[i+1]),
      .data_o  (sq_d[i+1])
    );
  end

  // ---- stage D: rounded root, offset products
  logic        d_v_q;
  side_t       d_side_q;
  logic [32:0] d_root_q, d_root_d;
  logic [64:0] d_px_q, d_pz_q;
  sqrt_t       sq_last;

  assign sq_last  = sq_d[SQRT_CELLS];
  // round to nearest: remainder above the root means sqrt > root + 1/2
  assign d_root_d = {1'b0, sq_last.root} +
                    33'((sq_last.rem > {2'b00, sq_last.root}) ? 1 : 0);

  // ---- stage E: rounding bias, divider chain head
  logic        e_v_q;
  div_t        e_data_q, e_data_d;
  logic [65:0] n_x, n_z;

  always_comb begin
    n_x = {1'b0, d_px_q} + {34'd0, d_root_q[32:1]};
    n_z = {1'b0, d_pz_q} + {34'd0, d_root_q[32:1]};
    e_data_d      = '0;
    e_data_d.side = d_side_q;
    e_data_d.d    = d_root_q;
    // quotient fits 32 bits, so the upper numerator bits lie below d
    e_data_d.rx   = n_x[64:32];
    e_data_d.rz   = n_z[64:32];
    e_data_d.nx   = n_x[31:0];
    e_data_d.nz   = n_z[31:0];
  end

  // ---- divider chain
  logic dv_v [DIV_CELLS+1];
  div_t dv_d [DIV_CELLS+1];
  assign dv_v[0] = e_v_q;
  assign dv_d[0] = e_data_q;

  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
    ccp_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_v[i]),
      .data_i  (dv_d[i]),
      .valid_o (dv_v[i+1]),
      .data_o  (dv_d[i+1])
    );
  end

  // ---- output stage: apply offset, saturate
  div_t               dv_last;
  logic signed [33:0] sum_x, sum_z;
  logic signed [31:0] res_x, res_z;
  logic               o_v_q;
  logic               o_hit_q, o_coin_q;
  logic signed [31:0] o_x_q, o_y_q, o_z_q;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -34'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  always_comb begin
    dv_last = dv_d[DIV_CELLS];
    sum_x = dv_last.side.sx ? 34'(dv_last.side.ax) - $signed({2'b00, dv_last.qx})
                            : 34'(dv_last.side.ax) + $signed({2'b00, dv_last.qx});
    sum_z = dv_last.side.sz ? 34'(dv_last.side.az) - $signed({2'b00, dv_last.qz})
                            : 34'(dv_last.side.az) + $signed({2'b00, dv_last.qz});
    res_x = dv_last.side.push ? sat32(sum_x) : dv_last.side.bx;
    res_z = dv_last.side.push ? sat32(sum_z) : dv_last.side.bz;
  end

  // ---- valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
      e_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= in_i.valid;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
      d_v_q <= sq_v[SQRT_CELLS];
      e_v_q <= d_v_q;
      o_v_q <= dv_v[DIV_CELLS];
    end
  end

  // ---- payload registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_side_q  <= a_side_d;
      a_vmiss_q <= a_vmiss_d;
      b_side_q  <= a_side_q;
      b_vmiss_q <= a_vmiss_q;
      b_sqx_q   <= a_side_q.mx * a_side_q.mx;
      b_sqz_q   <= a_side_q.mz * a_side_q.mz;
      b_rr_q    <= a_side_q.rng * a_side_q.rng;
      c_data_q  <= c_data_d;
      d_side_q  <= sq_last.side;
      d_root_q  <= d_root_d;
      d_px_q    <= sq_last.side.mx * sq_last.side.rng;
      d_pz_q    <= sq_last.side.mz * sq_last.side.rng;
      e_data_q  <= e_data_d;
      o_hit_q   <= dv_last.side.hit;
      o_coin_q  <= dv_last.side.coin;
      o_x_q     <= res_x;
      o_y_q     <= dv_last.side.by;
      o_z_q     <= res_z;
    end
  end

  assign out_o.valid      = o_v_q;
  assign out_o.hit        = o_hit_q;
  assign out_o.coincident = o_coin_q;
  assign out_o.pushed_x   = o_x_q;
  assign out_o.pushed_y   = o_y_q;
  assign out_o.pushed_z   = o_z_q;

  // ---- assertions
  a_coin_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.coincident |-> out_o.hit)
    else $error("coincident result without hit");

  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |-> !in_i.ready)
    else $error("input taken while pipeline is stalled");

  a_coin_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.hit |-> !out_o.coincident)
    else $error("miss flagged as coincident");

endmodule
